// ===== design/mwra_pkg.sv =====
package mwra_pkg;

	localparam int FRAME_BITS    = 32;
	localparam int READBACK_BITS = 27;
	localparam int ADDR_BITS     = 5;
	localparam int HP_BITS       = 16;

	// Command queue depth between front and back
	localparam int CMD_DEPTH_DEF = 2;

	localparam logic [HP_BITS-1:0]    HALF_PERIOD_RST = 16'd50;
	localparam logic [ADDR_BITS-1:0]  READ_TARGET     = 5'd31;
	localparam logic [ADDR_BITS-1:0]  FIXUP_LAST_ADDR = 5'd5;
	localparam logic [FRAME_BITS-1:0] FIXUP_FRAME     = 32'h5555_5549;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef struct packed {
		logic                     func;
		logic [ADDR_BITS-1:0]     reg_address;
		logic [FRAME_BITS-1:0]    write_data;
		logic [READBACK_BITS-1:0] readback_bits;
	} request_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame_word;
		logic [FRAME_BITS-1:0] rdbk_word;
		logic                  last;
	} result_t;

	// One serial frame for the back end to run
	typedef struct packed {
		logic [FRAME_BITS-1:0]    frame;
		logic [READBACK_BITS-1:0] rbk;
		logic [ADDR_BITS-1:0]     addr;
		logic                     rd;
		logic                     last;
	} cmd_t;

endpackage

// ===== design/mwra_front.sv =====
module mwra_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mwra_pkg::request_t request,
	output logic              full,
	input  logic              cmd_full,
	output logic              cmd_push,
	output mwra_pkg::cmd_t    cmd
);
	import mwra_pkg::*;

	logic  accept;
	logic  pend_valid_q;
	cmd_t  pend_q;
	cmd_t  first_cmd;
	logic  needs_fixup;

	assign full   = pend_valid_q || cmd_full;
	assign accept = push && !full;

	// Classify the request into its first frame
	always_comb begin
		first_cmd      = '0;
		first_cmd.rbk  = request.readback_bits;
		first_cmd.addr = request.reg_address;
		needs_fixup    = 1'b0;
		if (request.func == FUNC_READ) begin
			first_cmd.frame = {11'd0, request.reg_address, 11'd0, READ_TARGET};
			first_cmd.rd    = 1'b1;
			first_cmd.last  = 1'b1;
		end else begin
			first_cmd.frame = {request.write_data[FRAME_BITS-1:ADDR_BITS],
				request.reg_address};
			first_cmd.rd    = 1'b0;
			needs_fixup     = (request.reg_address <= FIXUP_LAST_ADDR);
			first_cmd.last  = !needs_fixup;
		end
	end

	assign cmd_push = accept || (pend_valid_q && !cmd_full);
	assign cmd      = accept ? first_cmd : pend_q;

	// Pending fixup frame for low-address writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_valid_q <= needs_fixup;
		end else if (pend_valid_q && !cmd_full) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= cmd_t'{frame: FIXUP_FRAME, rbk: '0, addr: '0, rd: 1'b0, last: 1'b1};
		end
	end

endmodule

// ===== design/mwra_cmd_fifo.sv =====
module mwra_cmd_fifo #(
	parameter int CMD_DEPTH = mwra_pkg::CMD_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mwra_pkg::cmd_t wr_cmd,
	output logic           q_full,
	input  logic           rd_en,
	output logic           q_empty,
	output mwra_pkg::cmd_t rd_cmd
);
	import mwra_pkg::*;

	localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(CMD_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== design/mwra_back.sv =====
module mwra_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mwra_pkg::HP_BITS-1:0]  half_period,
	input  logic                          cmd_empty,
	input  mwra_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	output logic                          empty,
	input  logic                          pop,
	output mwra_pkg::result_t             result
);
	import mwra_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_LATCH = 3'd2;
	localparam logic [2:0] ST_RDBK  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]               state_q;
	logic [HP_BITS-1:0]       timer_q;
	logic                     phase_q;   // serial clock level
	logic [4:0]               bit_cnt_q;
	logic                     tick;
	logic                     out_valid_q;
	logic                     slot_free;

	logic [FRAME_BITS-1:0]    sr_q;      // outgoing frame
	logic [FRAME_BITS-1:0]    cap_q;     // bits seen on the data line
	logic [READBACK_BITS-1:0] rbk_q;     // readback pin stimulus
	logic [READBACK_BITS-1:0] rd_cap_q;  // bits sampled on the readback pin
	logic [ADDR_BITS-1:0]     addr_q;
	logic                     rd_q;
	logic                     last_q;
	result_t                  result_q;

	assign tick      = (timer_q == '0);
	assign slot_free = !out_valid_q || pop;
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign empty     = !out_valid_q;
	assign result    = result_q;

	// Sequencer: half-period timer, clock phase and bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timer_q     <= '0;
			phase_q     <= 1'b0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result flag: set as a finished frame lands, cleared when taken
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != ST_IDLE && state_q != ST_DONE) begin
				timer_q <= tick ? half_period - 1'b1 : timer_q - 1'b1;
				if (tick) begin
					phase_q <= !phase_q;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						state_q   <= ST_SHIFT;
						timer_q   <= half_period - 1'b1;
						phase_q   <= 1'b0;
						bit_cnt_q <= '0;
					end
				end
				ST_SHIFT: begin
					if (tick && phase_q) begin
						if (bit_cnt_q == 5'(FRAME_BITS - 1)) begin
							state_q <= ST_LATCH;
						end
						bit_cnt_q <= bit_cnt_q + 1'b1;
					end
				end
				ST_LATCH: begin
					// latch-enable high for one half period, then low
					if (tick && phase_q) begin
						bit_cnt_q <= '0;
						state_q   <= rd_q ? ST_RDBK : ST_DONE;
					end
				end
				ST_RDBK: begin
					if (tick && phase_q) begin
						if (bit_cnt_q == 5'(READBACK_BITS - 1)) begin
							state_q <= ST_DONE;
						end
						bit_cnt_q <= bit_cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: shift out, capture on rising serial clock
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					sr_q   <= cmd.frame;
					rbk_q  <= cmd.rbk;
					addr_q <= cmd.addr;
					rd_q   <= cmd.rd;
					last_q <= cmd.last;
				end
			end
			ST_SHIFT: begin
				if (tick && !phase_q) begin
					cap_q <= {cap_q[FRAME_BITS-2:0], sr_q[FRAME_BITS-1]};
				end else if (tick && phase_q) begin
					sr_q <= {sr_q[FRAME_BITS-2:0], 1'b0};
				end
			end
			ST_RDBK: begin
				if (tick && !phase_q) begin
					rd_cap_q <= {rd_cap_q[READBACK_BITS-2:0], rbk_q[READBACK_BITS-1]};
				end else if (tick && phase_q) begin
					rbk_q <= {rbk_q[READBACK_BITS-2:0], 1'b0};
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					result_q.frame_word <= cap_q;
					result_q.rdbk_word  <= rd_q ? {rd_cap_q, addr_q} : '0;
					result_q.last       <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/microwire_register_access_master.sv =====
// A read clocks in the 27 readback bits after the latch pulse. Requests queue ahead of
// the sequencer, so a new one is taken while a frame still runs, until the queue is full;
// a write to 0..5 runs two frames. A result left waiting holds the sequencer.
// Reset clears the queue, the sequencer and the result flag; half period returns to 50.
module microwire_register_access_master #(
	parameter int CMD_DEPTH = mwra_pkg::CMD_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  mwra_pkg::request_t           request,
	output logic                         full,
	output logic                         empty,
	input  logic                         pop,
	output mwra_pkg::result_t            result,
	input  logic                         cfg_wr_en,
	input  logic [mwra_pkg::HP_BITS-1:0] cfg_wr_data
);
	import mwra_pkg::*;

	logic [HP_BITS-1:0] half_period_q;
	logic               cmd_full;
	logic               cmd_push;
	cmd_t               front_cmd;
	logic               cmd_empty;
	logic               cmd_pop;
	cmd_t               back_cmd;

	// Half period register; zero is held as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (cfg_wr_en) begin
			half_period_q <= (cfg_wr_data == '0) ? HP_BITS'(1) : cfg_wr_data;
		end
	end

	mwra_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	mwra_cmd_fifo #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_cmd  (front_cmd),
		.q_full  (cmd_full),
		.rd_en   (cmd_pop),
		.q_empty (cmd_empty),
		.rd_cmd  (back_cmd)
	);

	mwra_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_period (half_period_q),
		.cmd_empty   (cmd_empty),
		.cmd         (back_cmd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule
